// ===== src/assert_macros.svh =====
// Assertion macros shared by the checking sections of the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define JSEF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// check that a condition leads to a consequence on the next clock edge
`define JSEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed on following cycle");

`endif

// ===== src/jsef_pkg.sv =====
// Types, codes and constants of the segment end finder.
`timescale 1ns / 1ps
package jsef_pkg;

  localparam int unsigned CountBits = 32;
  localparam int unsigned MinStartBytes = 4;

  localparam logic [7:0] MarkPrefix = 8'hFF;
  localparam logic [7:0] MarkSoi    = 8'hD8;
  localparam logic [7:0] MarkEoi    = 8'hD9;
  localparam logic [7:0] MarkSos    = 8'hDA;
  localparam logic [7:0] MarkRstLo  = 8'hD0;
  localparam logic [7:0] MarkRstHi  = 8'hD7;
  localparam logic [7:0] MarkTem    = 8'h01;
  localparam logic [7:0] MarkStuff  = 8'h00;

  localparam logic [6:0] ConfValid   = 7'd95;
  localparam logic [6:0] ConfPartial = 7'd35;
  localparam logic [6:0] ConfNone    = 7'd0;

  localparam logic [31:0] MinSizeReset = 32'd4;

  typedef enum logic [3:0] {
    PH_SOI0,
    PH_SOI1,
    PH_BAD,
    PH_WALK,
    PH_MARK,
    PH_SEGH,
    PH_SEGL,
    PH_SEGSKIP,
    PH_SOSH,
    PH_SOSL,
    PH_SOSSKIP,
    PH_SEARCH,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_PARTIAL = 2'd1,
    ST_VALID   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CA_END_FOUND   = 2'd0,
    CA_BELOW_MIN   = 2'd1,
    CA_BAD_START   = 2'd2,
    CA_END_MISSING = 2'd3
  } cause_e;

  typedef struct packed {
    status_e     status;
    cause_e      cause;
    logic [31:0] true_length;
    logic [6:0]  confidence;
  } verdict_t;

endpackage

// ===== src/jsef_byte_if.sv =====
// Byte stream channel: valid, ready, data byte and last flag.
`timescale 1ns / 1ps
interface jsef_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/jsef_result_if.sv =====
// Result channel: valid, ready and the verdict fields.
`timescale 1ns / 1ps
interface jsef_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  cause;
  logic [31:0] true_length;
  logic [6:0]  confidence;

  modport source (output valid, output status, output cause, output true_length,
                  output confidence, input ready);
  modport sink (input valid, input status, input cause, input true_length,
                input confidence, output ready);
endinterface

// ===== src/jsef_parser.sv =====
// Marker segment walker: parse state, per-byte update and end-of-stream verdict.
`timescale 1ns / 1ps
module jsef_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  logic [31:0]        min_size_i,
  output jsef_pkg::verdict_t verdict_o
);
  import jsef_pkg::*;

  localparam logic [CountBits-1:0] CountMax = '1;

  phase_e               phase_q, phase_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [15:0]          skip_q, skip_d;
  logic [7:0]           len_hi_q, len_hi_d;
  logic [CountBits-1:0] fallback_q, fallback_d;
  logic [CountBits-1:0] end_pos_q, end_pos_d;
  logic                 prev_ff_q, prev_ff_d;
  logic                 start_ok_q, start_ok_d;

  logic [15:0] seg_len;
  logic [15:0] skip_dec;
  logic        is_ff;
  logic        is_eoi;
  logic        is_alone;
  logic        eoi_pair;

  assign seg_len  = {len_hi_q, byte_i};
  assign skip_dec = skip_q - 16'd1;
  assign is_ff    = (byte_i == MarkPrefix);
  assign is_eoi   = (byte_i == MarkEoi);
  assign is_alone = (byte_i inside {[MarkRstLo:MarkRstHi], MarkTem, MarkStuff});
  assign eoi_pair = prev_ff_q && is_eoi;
  assign count_d  = (count_q == CountMax) ? count_q : count_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_SOI0:    phase_d = is_ff ? PH_SOI1 : PH_BAD;
      PH_SOI1:    phase_d = (byte_i == MarkSoi) ? PH_WALK : PH_BAD;
      PH_WALK:    if (is_ff) phase_d = PH_MARK;
      PH_MARK: begin
        if (is_ff) begin
          phase_d = PH_MARK;
        end else if (is_eoi) begin
          phase_d = PH_DONE;
        end else if (byte_i == MarkSos) begin
          phase_d = PH_SOSH;
        end else if (is_alone) begin
          phase_d = PH_WALK;
        end else begin
          phase_d = PH_SEGH;
        end
      end
      PH_SEGH:    phase_d = PH_SEGL;
      PH_SEGL: begin
        if (seg_len < 16'd2) begin
          phase_d = PH_SEARCH;
        end else if (seg_len == 16'd2) begin
          phase_d = PH_WALK;
        end else begin
          phase_d = PH_SEGSKIP;
        end
      end
      PH_SEGSKIP: if (skip_dec == '0) phase_d = PH_WALK;
      PH_SOSH:    phase_d = PH_SOSL;
      PH_SOSL:    phase_d = (seg_len <= 16'd2) ? PH_SEARCH : PH_SOSSKIP;
      PH_SOSSKIP: if (skip_dec == '0) phase_d = PH_SEARCH;
      PH_SEARCH:  if (eoi_pair) phase_d = PH_DONE;
      PH_BAD, PH_DONE: phase_d = phase_q;
      default:    phase_d = phase_q;
    endcase
  end

  always_comb begin
    skip_d     = skip_q;
    len_hi_d   = len_hi_q;
    fallback_d = fallback_q;
    end_pos_d  = end_pos_q;
    prev_ff_d  = prev_ff_q;
    start_ok_d = start_ok_q;
    case (phase_q)
      PH_SOI1: if (byte_i == MarkSoi) start_ok_d = 1'b1;
      PH_MARK: begin
        if (is_eoi) begin
          end_pos_d = count_d;
        end else if (!is_ff && byte_i != MarkSos && !is_alone) begin
          prev_ff_d  = 1'b0;
          fallback_d = '0;
        end
      end
      PH_SEGH: begin
        len_hi_d  = byte_i;
        prev_ff_d = is_ff;
      end
      PH_SEGL: begin
        if (eoi_pair && fallback_q == '0) fallback_d = count_d;
        prev_ff_d = is_ff;
        if (seg_len == 16'd2) begin
          fallback_d = '0;
        end else if (seg_len > 16'd2) begin
          skip_d = seg_len - 16'd2;
        end
      end
      PH_SEGSKIP: begin
        if (eoi_pair && fallback_q == '0) fallback_d = count_d;
        prev_ff_d = is_ff;
        skip_d    = skip_dec;
        if (skip_dec == '0) fallback_d = '0;
      end
      PH_SOSH: len_hi_d = byte_i;
      PH_SOSL: begin
        prev_ff_d = 1'b0;
        if (seg_len > 16'd2) skip_d = seg_len - 16'd2;
      end
      PH_SOSSKIP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) prev_ff_d = 1'b0;
      end
      PH_SEARCH: begin
        if (eoi_pair) end_pos_d = count_d;
        prev_ff_d = is_ff;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    verdict_o.status      = ST_PARTIAL;
    verdict_o.cause       = CA_END_MISSING;
    verdict_o.confidence  = ConfPartial;
    verdict_o.true_length = (64'(count_d) > 64'h0000_0000_FFFF_FFFF) ? '1 : 32'(count_d);
    if (64'(count_d) < 64'(min_size_i)) begin
      verdict_o.status      = ST_INVALID;
      verdict_o.cause       = CA_BELOW_MIN;
      verdict_o.confidence  = ConfNone;
      verdict_o.true_length = '0;
    end else if (64'(count_d) < 64'(MinStartBytes) || !start_ok_d) begin
      verdict_o.status      = ST_INVALID;
      verdict_o.cause       = CA_BAD_START;
      verdict_o.confidence  = ConfNone;
      verdict_o.true_length = '0;
    end else if (end_pos_d != '0) begin
      verdict_o.status      = ST_VALID;
      verdict_o.cause       = CA_END_FOUND;
      verdict_o.confidence  = ConfValid;
      verdict_o.true_length =
        (64'(end_pos_d) > 64'h0000_0000_FFFF_FFFF) ? '1 : 32'(end_pos_d);
    end else if (phase_d == PH_SEGSKIP && fallback_d != '0) begin
      verdict_o.status      = ST_VALID;
      verdict_o.cause       = CA_END_FOUND;
      verdict_o.confidence  = ConfValid;
      verdict_o.true_length =
        (64'(fallback_d) > 64'h0000_0000_FFFF_FFFF) ? '1 : 32'(fallback_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SOI0;
      count_q    <= '0;
      skip_q     <= '0;
      len_hi_q   <= '0;
      fallback_q <= '0;
      end_pos_q  <= '0;
      prev_ff_q  <= 1'b0;
      start_ok_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q    <= PH_SOI0;
        count_q    <= '0;
        skip_q     <= '0;
        len_hi_q   <= '0;
        fallback_q <= '0;
        end_pos_q  <= '0;
        prev_ff_q  <= 1'b0;
        start_ok_q <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        count_q    <= count_d;
        skip_q     <= skip_d;
        len_hi_q   <= len_hi_d;
        fallback_q <= fallback_d;
        end_pos_q  <= end_pos_d;
        prev_ff_q  <= prev_ff_d;
        start_ok_q <= start_ok_d;
      end
    end
  end

endmodule

// ===== src/jpeg_segment_end_finder_unit.sv =====
// Path: an accepted byte is held in the input register; the verdict for a last
//   byte goes into the result register when no earlier result waits untaken.
// Throughput: one byte per cycle; a last byte waits in the input register only
//   while an earlier result is not taken.
// Reset: parser state cleared to expect the start marker, min_size set to 4.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jpeg_segment_end_finder_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  jsef_byte_if.sink     in_i,
  jsef_result_if.source out_o
);
  import jsef_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q;
  verdict_t   result_q;
  verdict_t   verdict;
  logic [31:0] min_size_q;
  logic       advance;
  logic       step;

  assign advance  = !(in_vld_q && in_last_q && out_vld_q && !out_o.ready);
  assign step     = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= MinSizeReset;
    end else if (cfg_we_i) begin
      min_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  jsef_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .min_size_i (min_size_q),
    .verdict_o  (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      result_q <= verdict;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = result_q.status;
  assign out_o.cause       = result_q.cause;
  assign out_o.true_length = result_q.true_length;
  assign out_o.confidence  = result_q.confidence;

  `JSEF_ASSERT(a_valid_fields, !(out_vld_q && result_q.status == ST_VALID) ||
    (result_q.confidence == ConfValid && result_q.cause == CA_END_FOUND &&
     result_q.true_length != '0))
  `JSEF_ASSERT(a_invalid_zero, !(out_vld_q && result_q.status == ST_INVALID) ||
    (result_q.confidence == ConfNone && result_q.true_length == '0))
  `JSEF_ASSERT(a_last_holds,
    !(in_vld_q && in_last_q && out_vld_q && !out_o.ready) || !in_i.ready)
  `JSEF_ASSERT_NEXT(a_last_loads, step && in_last_q, out_vld_q)

endmodule

// ===== dv/jpeg_segment_end_finder_unit_tb.sv =====
// Self-checking bench for the JPEG segment end finder: directed and random byte streams.
`timescale 1ns / 1ps
module jpeg_segment_end_finder_unit_tb;
  import jsef_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 4;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  jsef_byte_if   in_if ();
  jsef_result_if out_if ();

  jpeg_segment_end_finder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #6 clk_i = ~clk_i;

  phase_e      scan_phase;
  logic [31:0] scan_count;
  logic [15:0] scan_skip;
  logic [7:0]  scan_len_hi;
  logic [31:0] scan_fallback;
  logic [31:0] scan_eoi_pos;
  logic        scan_prev_ff;
  logic        scan_soi_ok;
  logic [31:0] min_size_now;

  verdict_t pending_verdicts[$];

  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;
  int unsigned bytes_sent    = 0;
  int unsigned streams_sent  = 0;
  int unsigned verdicts_seen = 0;
  int unsigned n_valid       = 0;
  int unsigned n_partial     = 0;
  int unsigned n_invalid     = 0;
  int unsigned src_idle_pct  = 29;
  int unsigned snk_idle_pct  = 60;

  function automatic void restart_scan();
    scan_phase    = PH_SOI0;
    scan_count    = '0;
    scan_skip     = '0;
    scan_len_hi   = '0;
    scan_fallback = '0;
    scan_eoi_pos  = '0;
    scan_prev_ff  = 1'b0;
    scan_soi_ok   = 1'b0;
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    logic [15:0] len_word;
    len_word = {scan_len_hi, b};
    if (scan_count != '1) scan_count = scan_count + 32'd1;
    case (scan_phase)
      PH_SOI0: scan_phase = (b == MarkPrefix) ? PH_SOI1 : PH_BAD;
      PH_SOI1: begin
        if (b == MarkSoi) begin
          scan_soi_ok = 1'b1;
          scan_phase  = PH_WALK;
        end else begin
          scan_phase = PH_BAD;
        end
      end
      PH_WALK: if (b == MarkPrefix) scan_phase = PH_MARK;
      PH_MARK: begin
        if (b == MarkPrefix) begin
          scan_phase = PH_MARK;
        end else if (b == MarkEoi) begin
          scan_eoi_pos = scan_count;
          scan_phase   = PH_DONE;
        end else if (b == MarkSos) begin
          scan_phase = PH_SOSH;
        end else if ((b >= MarkRstLo && b <= MarkRstHi) || b == MarkTem || b == MarkStuff) begin
          scan_phase = PH_WALK;
        end else begin
          scan_prev_ff  = 1'b0;
          scan_fallback = '0;
          scan_phase    = PH_SEGH;
        end
      end
      PH_SEGH: begin
        scan_len_hi  = b;
        scan_prev_ff = (b == MarkPrefix);
        scan_phase   = PH_SEGL;
      end
      PH_SEGL: begin
        if (scan_prev_ff && b == MarkEoi && scan_fallback == 0) scan_fallback = scan_count;
        scan_prev_ff = (b == MarkPrefix);
        if (len_word < 16'd2) begin
          scan_phase = PH_SEARCH;
        end else if (len_word == 16'd2) begin
          scan_fallback = '0;
          scan_phase    = PH_WALK;
        end else begin
          scan_skip  = len_word - 16'd2;
          scan_phase = PH_SEGSKIP;
        end
      end
      PH_SEGSKIP: begin
        if (scan_prev_ff && b == MarkEoi && scan_fallback == 0) scan_fallback = scan_count;
        scan_prev_ff = (b == MarkPrefix);
        scan_skip    = scan_skip - 16'd1;
        if (scan_skip == 0) begin
          scan_fallback = '0;
          scan_phase    = PH_WALK;
        end
      end
      PH_SOSH: begin
        scan_len_hi = b;
        scan_phase  = PH_SOSL;
      end
      PH_SOSL: begin
        scan_prev_ff = 1'b0;
        if (len_word <= 16'd2) begin
          scan_phase = PH_SEARCH;
        end else begin
          scan_skip  = len_word - 16'd2;
          scan_phase = PH_SOSSKIP;
        end
      end
      PH_SOSSKIP: begin
        scan_skip = scan_skip - 16'd1;
        if (scan_skip == 0) begin
          scan_prev_ff = 1'b0;
          scan_phase   = PH_SEARCH;
        end
      end
      PH_SEARCH: begin
        if (scan_prev_ff && b == MarkEoi) begin
          scan_eoi_pos = scan_count;
          scan_phase   = PH_DONE;
        end
        scan_prev_ff = (b == MarkPrefix);
      end
      default: ;
    endcase
  endfunction

  function automatic verdict_t close_stream();
    verdict_t v;
    if (scan_count < min_size_now) begin
      v = '{status: ST_INVALID, cause: CA_BELOW_MIN, true_length: '0, confidence: ConfNone};
    end else if (scan_count < MinStartBytes || !scan_soi_ok) begin
      v = '{status: ST_INVALID, cause: CA_BAD_START, true_length: '0, confidence: ConfNone};
    end else if (scan_eoi_pos != 0) begin
      v = '{status: ST_VALID, cause: CA_END_FOUND, true_length: scan_eoi_pos,
            confidence: ConfValid};
    end else if (scan_phase == PH_SEGSKIP && scan_fallback != 0) begin
      v = '{status: ST_VALID, cause: CA_END_FOUND, true_length: scan_fallback,
            confidence: ConfValid};
    end else begin
      v = '{status: ST_PARTIAL, cause: CA_END_MISSING, true_length: scan_count,
            confidence: ConfPartial};
    end
    restart_scan();
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      report_mismatch($sformatf("verdict status %0d length %0d with no stream closed",
                                out_if.status, out_if.true_length));
    end else begin
      want = pending_verdicts.pop_front();
      verdicts_seen++;
      case (want.status)
        ST_VALID:   n_valid++;
        ST_PARTIAL: n_partial++;
        default:    n_invalid++;
      endcase
      if (out_if.status !== want.status)
        report_mismatch($sformatf("verdict %0d status got %0d want %0d", verdicts_seen,
                                  out_if.status, want.status));
      if (out_if.cause !== want.cause)
        report_mismatch($sformatf("verdict %0d cause got %0d want %0d", verdicts_seen,
                                  out_if.cause, want.cause));
      if (out_if.true_length !== want.true_length)
        report_mismatch($sformatf("verdict %0d length got %0d want %0d", verdicts_seen,
                                  out_if.true_length, want.true_length));
      if (out_if.confidence !== want.confidence)
        report_mismatch($sformatf("verdict %0d confidence got %0d want %0d", verdicts_seen,
                                  out_if.confidence, want.confidence));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        scan_byte(in_if.data_byte);
        if (in_if.last_byte) pending_verdicts.push_back(close_stream());
      end
      if (out_if.valid && out_if.ready) check_verdict();
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles,
               pending_verdicts.size());
      $display("jpeg_segment_end_finder_unit_tb failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= is_last;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_stream(input byte_q_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    streams_sent++;
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_min_size(input logic [31:0] value);
    hold_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    min_size_now = value;
  endtask

  function automatic logic [7:0] spicy_byte();
    case ($urandom_range(9))
      0, 1:    return MarkPrefix;
      2:       return MarkEoi;
      3:       return MarkStuff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic byte_q_t random_stream();
    byte_q_t     s;
    int unsigned seg_len;
    int unsigned pick;
    logic [7:0]  code;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) s.push_back(spicy_byte());
      return s;
    end
    s = '{MarkPrefix, MarkSoi};
    repeat ($urandom_range(0, 4)) begin
      pick = $urandom_range(9);
      if (pick < 2) begin
        repeat ($urandom_range(0, 2)) s.push_back(MarkPrefix);
        s.push_back(MarkPrefix);
        case ($urandom_range(3))
          0:       s.push_back(MarkTem);
          1:       s.push_back(MarkStuff);
          default: s.push_back(MarkRstLo + 8'($urandom_range(7)));
        endcase
      end else if (pick < 3) begin
        s.push_back(8'($urandom_range(254)));
      end else begin
        code = 8'($urandom_range(255));
        if (code == MarkPrefix || code == MarkEoi || code == MarkSos || code == MarkTem ||
            code == MarkStuff || (code >= MarkRstLo && code <= MarkRstHi)) code = 8'hE0;
        s.push_back(MarkPrefix);
        s.push_back(code);
        // end the stream inside a long segment
        if ($urandom_range(19) == 0) begin
          s.push_back(8'($urandom_range(1, 255)));
          s.push_back(8'($urandom_range(255)));
          repeat ($urandom_range(0, 6)) s.push_back(spicy_byte());
          return s;
        end
        seg_len = ($urandom_range(9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
        s.push_back(8'(seg_len >> 8));
        s.push_back(8'(seg_len));
        if (seg_len > 2) repeat (seg_len - 2) s.push_back(spicy_byte());
      end
    end
    pick = $urandom_range(9);
    if (pick < 6) begin
      seg_len = ($urandom_range(4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      s.push_back(MarkPrefix);
      s.push_back(MarkSos);
      s.push_back(8'(seg_len >> 8));
      s.push_back(8'(seg_len));
      if (seg_len > 2) repeat (seg_len - 2) s.push_back(spicy_byte());
      repeat ($urandom_range(0, 10)) begin
        if ($urandom_range(3) == 0) begin
          s.push_back(MarkPrefix);
          s.push_back($urandom_range(1) ? MarkStuff : MarkRstLo + 8'($urandom_range(7)));
        end else begin
          s.push_back(8'($urandom_range(254)));
        end
      end
      if ($urandom_range(9) != 0) begin
        s.push_back(MarkPrefix);
        s.push_back(MarkEoi);
      end
    end else if (pick < 9) begin
      s.push_back(MarkPrefix);
      s.push_back(MarkEoi);
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) s.push_back(spicy_byte());
    // truncate or corrupt
    if ($urandom_range(9) < 2) repeat ($urandom_range(1, s.size() - 1)) void'(s.pop_back());
    if ($urandom_range(9) == 0) s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(255));
    return s;
  endfunction

  task automatic test_size_floor();
    send_stream('{MarkPrefix});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, MarkEoi});
  endtask

  task automatic test_start_marker();
    send_stream('{MarkStuff, MarkSoi, MarkPrefix, MarkEoi});
    send_stream('{MarkPrefix, MarkStuff, MarkPrefix, MarkEoi, MarkStuff});
    send_stream('{MarkPrefix, MarkPrefix, MarkSoi, MarkPrefix, MarkEoi});
  endtask

  task automatic test_marker_walk();
    send_stream('{MarkPrefix, MarkSoi, 8'h12, 8'h34, MarkPrefix, MarkPrefix, MarkPrefix,
                  MarkRstLo, MarkPrefix, MarkTem, MarkPrefix, MarkStuff, MarkPrefix, MarkRstHi,
                  MarkPrefix, 8'hE0, 8'h00, 8'h04, 8'hAA, 8'hBB, MarkPrefix, MarkEoi,
                  8'h55, 8'h66});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, 8'hE0, 8'h00, 8'h02, MarkPrefix, MarkEoi});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, MarkPrefix});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, 8'hE1, 8'h00});
  endtask

  task automatic test_segment_overrun();
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, 8'hE1, 8'h00, 8'h10, 8'h11, MarkPrefix,
                  MarkEoi, 8'h22});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, 8'hE1, 8'h00, 8'h10, 8'h11, 8'h22});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, 8'hE1, MarkPrefix, MarkEoi, 8'h33});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, 8'hE1, MarkPrefix, MarkPrefix, MarkPrefix,
                  MarkEoi});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, 8'hE1, 8'h00, 8'h04, MarkPrefix, MarkEoi,
                  8'hAB});
  endtask

  task automatic test_malformed_length();
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, 8'hE1, 8'h00, 8'h01, 8'h12, MarkPrefix,
                  MarkEoi, 8'h44});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, 8'hE1, 8'h00, 8'h00, MarkPrefix, 8'h33});
  endtask

  task automatic test_entropy_scan();
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, MarkSos, 8'h00, 8'h04, MarkPrefix, MarkEoi,
                  8'h12, MarkPrefix, MarkStuff, MarkPrefix, 8'hD3, MarkPrefix, MarkPrefix,
                  MarkEoi});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, MarkSos, 8'h00, 8'h00, MarkPrefix, MarkEoi});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, MarkSos, 8'h00, 8'h01, MarkEoi, MarkPrefix,
                  MarkEoi});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, MarkSos, 8'h00, 8'h02, 8'hAB, MarkPrefix});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, MarkSos, 8'h01, 8'h00, MarkPrefix, MarkEoi});
  endtask

  task automatic test_min_size_extremes();
    write_min_size(32'd0);
    send_stream('{MarkPrefix});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix});
    write_min_size('1);
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, MarkEoi});
    write_min_size(32'd6);
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, MarkEoi, 8'h00, 8'h00});
    send_stream('{MarkPrefix, MarkSoi, MarkPrefix, MarkEoi, 8'h00});
    write_min_size(MinSizeReset);
  endtask

  task automatic test_random_streams(input int unsigned src_pct, input int unsigned snk_pct,
                                     input int unsigned byte_goal);
    int unsigned start_bytes;
    int unsigned n;
    logic [31:0] floor_value;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start_bytes  = bytes_sent;
    n            = 0;
    while (bytes_sent - start_bytes < byte_goal) begin
      if (n % 12 == 0) begin
        case ($urandom_range(9))
          0:       floor_value = 32'd0;
          1:       floor_value = $urandom_range(1) ? '1 : $urandom;
          2, 3, 4: floor_value = MinSizeReset;
          default: floor_value = $urandom_range(0, 30);
        endcase
        write_min_size(floor_value);
      end else if ($urandom_range(7) == 0) begin
        hold_until_drained();
      end
      send_stream(random_stream());
      n++;
    end
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    restart_scan();
    min_size_now = MinSizeReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_size_floor();
    test_start_marker();
    test_marker_walk();
    test_segment_overrun();
    test_malformed_length();
    test_entropy_scan();
    test_min_size_extremes();
    test_random_streams(29, 60, 360);
    test_random_streams(60, 29, 360);
    test_random_streams(0, 0, 340);

    hold_until_drained();
    repeat (2 * SettleCycles) @(posedge clk_i);
    $display("Covered %0d streams, %0d bytes; %0d verdicts checked", streams_sent,
             bytes_sent, verdicts_seen);
    $display("(%0d valid, %0d partial, %0d invalid), min_size swept; %0d mismatches",
             n_valid, n_partial, n_invalid, mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("jpeg_segment_end_finder_unit_tb passed");
    end else begin
      $display("jpeg_segment_end_finder_unit_tb failed");
    end
    $finish;
  end

endmodule
